// File: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_LISTED    = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_UNDERFLOW = 3'd3,
    STS_OVERFLOW  = 3'd4,
    STS_IGNORED   = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic signed [DATA_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
    logic [CNT_W-1:0]          count;
  } out_t;

endpackage

// File: src/deq_ram.sv
// Entry store: one write port, one read port with registered read data.
module deq_ram #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic signed [deq_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic signed [deq_pkg::DATA_W-1:0] rdata
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/double_ended_queue_unit.sv
// Single-result items: result is registered in the cycle after the input transfer; one item per
// cycle while the output is taken. The single output register sets that figure.
// Listing of N elements: first passes state, store read and output registers, then one element
// per cycle while output is taken (one store read each); next item taken after last is loaded.
// Reset clears head, count, halt flag and output valid; store contents stay undefined and
// need no clearing pass, since only written entries are ever read.
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::out_t out_item
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              halted, halted_next;
  logic [CW-1:0]     iss, iss_next;
  logic              pend, pend_next;
  logic              out_valid_next;
  out_t              out_item_next;

  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] rdata;

  logic              out_free;
  logic              load, issue;
  logic [CW-1:0]     cnt_inc, cnt_dec;
  logic [AW-1:0]     front_idx, head_inc, rear_idx, list_idx;
  logic [AW:0]       rear_sum, list_sum;

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Circular index arithmetic
  always_comb begin
    front_idx = (head == '0) ? LAST_IDX : head - 1'b1;
    head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
    rear_sum  = {1'b0, head} + (AW + 1)'(cnt);
    rear_idx  = (rear_sum >= DEPTH_W) ? AW'(rear_sum - DEPTH_W) : AW'(rear_sum);
    list_sum  = {1'b0, head} + (AW + 1)'(iss);
    list_idx  = (list_sum >= DEPTH_W) ? AW'(list_sum - DEPTH_W) : AW'(list_sum);
    cnt_inc   = cnt + 1'b1;
    cnt_dec   = cnt - 1'b1;
  end

  // Next state, store access and result
  always_comb begin
    state_next     = state;
    head_next      = head;
    cnt_next       = cnt;
    halted_next    = halted;
    iss_next       = iss;
    pend_next      = pend;
    out_item_next  = out_item;
    out_free       = !out_valid || out_ready;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    we             = 1'b0;
    waddr          = rear_idx;
    re             = 1'b0;
    raddr          = list_idx;
    load           = 1'b0;
    issue          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          out_item_next.status = STS_DONE;
          out_item_next.data   = '0;
          out_item_next.last   = 1'b1;
          out_item_next.count  = CNT_W'(cnt);
          if (halted) begin
            out_valid_next       = 1'b1;
            out_item_next.status = STS_IGNORED;
          end else begin
            case (in_item.opcode) inside
              OP_PUSH_FRONT, OP_PUSH_REAR: begin
                out_valid_next = 1'b1;
                if (cnt == FULL_CNT) begin
                  out_item_next.status = STS_OVERFLOW;
                end else begin
                  // Front push moves the head back and writes there
                  we = 1'b1;
                  if (in_item.opcode == OP_PUSH_FRONT) begin
                    waddr     = front_idx;
                    head_next = front_idx;
                  end
                  cnt_next            = cnt_inc;
                  out_item_next.count = CNT_W'(cnt_inc);
                end
              end
              OP_POP_FRONT, OP_POP_REAR: begin
                out_valid_next = 1'b1;
                if (cnt == '0) begin
                  out_item_next.status = STS_UNDERFLOW;
                  halted_next          = 1'b1;
                end else begin
                  if (in_item.opcode == OP_POP_FRONT) begin
                    head_next = head_inc;
                  end
                  cnt_next            = cnt_dec;
                  out_item_next.count = CNT_W'(cnt_dec);
                end
              end
              OP_LIST: begin
                if (cnt == '0) begin
                  out_valid_next       = 1'b1;
                  out_item_next.status = STS_EMPTY;
                end else begin
                  state_next = ST_LIST;
                  iss_next   = '0;
                  pend_next  = 1'b0;
                end
              end
              default: begin
                // Unused opcodes: drop silently
              end
            endcase
          end
        end
      end

      ST_LIST: begin
        // Load a fetched element when the output register frees up
        load  = pend && out_free;
        issue = (iss < cnt) && (!pend || load);
        if (load) begin
          out_valid_next       = 1'b1;
          out_item_next.status = STS_LISTED;
          out_item_next.data   = rdata;
          out_item_next.last   = (iss == cnt);
          out_item_next.count  = CNT_W'(cnt);
        end
        // Fetch the next element
        if (issue) begin
          re       = 1'b1;
          iss_next = iss + 1'b1;
        end
        pend_next = issue || (pend && !load);
        if (load && (iss == cnt)) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      cnt       <= '0;
      halted    <= 1'b0;
      iss       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      cnt       <= cnt_next;
      halted    <= halted_next;
      iss       <= iss_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_item <= out_item_next;
  end

endmodule
